// ===== rtl/core/morse_character_keyer_unit_defines.svh =====
// Assertion macros shared by the keyer RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef MORSE_CHARACTER_KEYER_UNIT_DEFINES_SVH
`define MORSE_CHARACTER_KEYER_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define MCK_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, off during reset
`define MCK_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/core/mck_pkg.sv =====
// Types, constants and code tables for the Morse character keyer.
// No dependencies; imported by every keyer module.
`timescale 1ns / 1ps
package mck_pkg;

  localparam int DASH_UNITS_DEF  = 3;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0] LETTER_A   = 8'h61;
  localparam logic [7:0] LETTER_Z   = 8'h7A;
  localparam logic [7:0] SPACE_CHAR = 8'h20;

  localparam logic [3:0] GAP_ELEMS   = 4'd2;
  localparam logic [3:0] SPACE_ELEMS = 4'd4;
  localparam logic [3:0] BAD_ELEMS   = 4'd1;

  typedef enum logic [1:0] {
    KIND_BAD,
    KIND_LETTER,
    KIND_SPACE
  } kind_t;

  // one classified character word
  typedef struct packed {
    kind_t       kind;
    logic [2:0]  cnt;
    logic [3:0]  bits;
  } desc_t;

  // symbol count per letter
  function automatic logic [2:0] sym_count(input logic [4:0] idx);
    logic [2:0] r;
    unique case (idx)
      5'd0:  r = 3'd2;
      5'd1:  r = 3'd4;
      5'd2:  r = 3'd4;
      5'd3:  r = 3'd3;
      5'd4:  r = 3'd1;
      5'd5:  r = 3'd4;
      5'd6:  r = 3'd3;
      5'd7:  r = 3'd4;
      5'd8:  r = 3'd2;
      5'd9:  r = 3'd4;
      5'd10: r = 3'd3;
      5'd11: r = 3'd4;
      5'd12: r = 3'd2;
      5'd13: r = 3'd2;
      5'd14: r = 3'd3;
      5'd15: r = 3'd4;
      5'd16: r = 3'd4;
      5'd17: r = 3'd3;
      5'd18: r = 3'd3;
      5'd19: r = 3'd1;
      5'd20: r = 3'd3;
      5'd21: r = 3'd4;
      5'd22: r = 3'd3;
      5'd23: r = 3'd4;
      5'd24: r = 3'd4;
      5'd25: r = 3'd4;
      default: r = 3'd1;
    endcase
    return r;
  endfunction

  // symbol bits per letter, first symbol in highest used bit, 1 = dash
  function automatic logic [3:0] sym_bits(input logic [4:0] idx);
    logic [3:0] r;
    unique case (idx)
      5'd0:  r = 4'h1;
      5'd1:  r = 4'h8;
      5'd2:  r = 4'hA;
      5'd3:  r = 4'h4;
      5'd4:  r = 4'h0;
      5'd5:  r = 4'h2;
      5'd6:  r = 4'h6;
      5'd7:  r = 4'h0;
      5'd8:  r = 4'h0;
      5'd9:  r = 4'h7;
      5'd10: r = 4'h5;
      5'd11: r = 4'h4;
      5'd12: r = 4'h3;
      5'd13: r = 4'h2;
      5'd14: r = 4'h7;
      5'd15: r = 4'h6;
      5'd16: r = 4'hD;
      5'd17: r = 4'h2;
      5'd18: r = 4'h0;
      5'd19: r = 4'h1;
      5'd20: r = 4'h1;
      5'd21: r = 4'h1;
      5'd22: r = 4'h3;
      5'd23: r = 4'h9;
      5'd24: r = 4'hB;
      5'd25: r = 4'hC;
      default: r = 4'h0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/mck_front.sv =====
// Front end: takes a character word and classifies it into a descriptor.
// Depends on mck_pkg.
`timescale 1ns / 1ps
module mck_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  logic [7:0]    char_code,
  input  logic          q_full,
  output logic          push,
  output mck_pkg::desc_t push_desc
);
  import mck_pkg::*;

  logic       valid;
  desc_t      desc;
  desc_t      desc_next;
  logic [4:0] idx;
  logic       accept;

  assign busy   = valid && q_full;
  assign accept = start && !busy;
  assign push   = valid && !q_full;
  assign push_desc = desc;

  always_comb begin
    idx = 5'(char_code - LETTER_A);
    desc_next.cnt  = 3'd0;
    desc_next.bits = 4'd0;
    priority if (char_code >= LETTER_A && char_code <= LETTER_Z) begin
      desc_next.kind = KIND_LETTER;
      desc_next.cnt  = sym_count(idx);
      desc_next.bits = sym_bits(idx);
    end else if (char_code == SPACE_CHAR) begin
      desc_next.kind = KIND_SPACE;
    end else begin
      desc_next.kind = KIND_BAD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (accept) begin
      valid <= 1'b1;
    end else if (push) begin
      valid <= 1'b0;
    end
    if (accept) begin
      desc <= desc_next;
    end
  end

endmodule

// ===== rtl/core/mck_queue.sv =====
// Short descriptor queue between front and back ends.
// Depends on mck_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "morse_character_keyer_unit_defines.svh"
module mck_queue #(
  parameter int DEPTH = mck_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mck_pkg::desc_t push_desc,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output mck_pkg::desc_t pop_desc
);
  import mck_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  desc_t         mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_desc = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
    if (push) begin
      mem[wr_ptr] <= push_desc;
    end
  end

  `MCK_ASSERT_IMP(a_no_push_full, clk, rst, push, !full)
  `MCK_ASSERT_IMP(a_no_pop_empty, clk, rst, pop, !empty)
  `MCK_ASSERT_IMP(a_count_range, clk, rst, 1'b1, count <= CW'(DEPTH))

endmodule

// ===== rtl/core/mck_back.sv =====
// Back end: plays a descriptor out as keying elements, one per cycle.
// Depends on mck_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "morse_character_keyer_unit_defines.svh"
module mck_back #(
  parameter int DASH_UNITS = mck_pkg::DASH_UNITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  mck_pkg::desc_t q_desc,
  output logic           pop,
  output logic           strobe,
  output logic           key_on,
  output logic [1:0]     length_units,
  output logic           bad_char,
  output logic           last
);
  import mck_pkg::*;

  typedef enum logic {IDLE, SEND} state_t;

  state_t     state;
  desc_t      cur;
  logic [3:0] step;
  logic [3:0] total;
  logic       is_last;
  logic [2:0] sym_idx;
  logic       elem_on;
  logic       elem_dash;

  always_comb begin
    unique case (cur.kind)
      KIND_LETTER: total = 4'({cur.cnt, 1'b0}) + GAP_ELEMS;
      KIND_SPACE:  total = SPACE_ELEMS;
      default:     total = BAD_ELEMS;
    endcase
    is_last   = (step == total - 4'd1);
    sym_idx   = cur.cnt - 3'd1 - step[3:1];
    elem_on   = (cur.kind == KIND_LETTER) && !step[0] && (step < 4'({cur.cnt, 1'b0}));
    elem_dash = cur.bits[sym_idx[1:0]];
  end

  assign pop = !q_empty && ((state == IDLE) || is_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= IDLE;
      strobe <= 1'b0;
    end else begin
      strobe <= (state == SEND);
      if (pop) begin
        state <= SEND;
      end else if (state == SEND && is_last) begin
        state <= IDLE;
      end
    end
    if (pop) begin
      cur  <= q_desc;
      step <= '0;
    end else if (state == SEND) begin
      step <= step + 4'd1;
    end
    key_on       <= elem_on;
    length_units <= (elem_on && elem_dash) ? 2'(DASH_UNITS) : 2'd1;
    bad_char     <= (cur.kind == KIND_BAD);
    last         <= is_last;
  end

  `MCK_ASSERT_IMP(a_step_range, clk, rst, state == SEND, step < total)
  `MCK_ASSERT_NXT(a_send_strobes, clk, rst, state == SEND, strobe)
  `MCK_ASSERT_NXT(a_idle_quiet, clk, rst, state == IDLE, !strobe)

endmodule

// ===== rtl/core/morse_character_keyer_unit.sv =====
// Morse character keyer: one character word in, its keying elements out.
// Path: a word is held in the front register, written to the queue, then loaded into
// the back end: 2*symbols+2 elements per letter, 4 per space, 1 per bad character,
// sent one element a cycle while words are queued; the queue hides front stalls.
// Reset: synchronous; clears queue, front and back state, no results pending.
`timescale 1ns / 1ps
module morse_character_keyer_unit #(
  parameter int DASH_UNITS  = mck_pkg::DASH_UNITS_DEF,
  parameter int QUEUE_DEPTH = mck_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] char_code,
  output logic       strobe,
  output logic       key_on,
  output logic [1:0] length_units,
  output logic       bad_char,
  output logic       last
);
  import mck_pkg::*;

  logic  push;
  logic  pop;
  logic  q_full;
  logic  q_empty;
  desc_t push_desc;
  desc_t pop_desc;

  mck_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .char_code (char_code),
    .q_full    (q_full),
    .push      (push),
    .push_desc (push_desc)
  );

  mck_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .pop_desc  (pop_desc)
  );

  mck_back #(
    .DASH_UNITS (DASH_UNITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_desc       (pop_desc),
    .pop          (pop),
    .strobe       (strobe),
    .key_on       (key_on),
    .length_units (length_units),
    .bad_char     (bad_char),
    .last         (last)
  );

endmodule

// ===== dv/morse_character_keyer_unit_tb.sv =====
// Self-checking bench for morse_character_keyer_unit: directed table, then random words.
// Depends on mck_pkg and the keyer RTL; own element predictor, random start gaps.
`timescale 1ns / 1ps
module morse_character_keyer_unit_tb;
  import mck_pkg::*;

  localparam int         N_RANDOM     = 356;
  localparam int         PRESSURE_AT  = N_RANDOM / 2;
  localparam int         CYCLE_LIMIT  = 200000;
  localparam int         DRAIN_CYCLES = 30;
  localparam int         N_DIR        = 24;
  localparam logic [1:0] DASH_LEN     = 2'(DASH_UNITS_DEF);

  typedef struct packed {
    logic       key_on;
    logic [1:0] length_units;
    logic       bad_char;
    logic       last;
  } element_t;

  typedef struct packed {
    logic [7:0]       code;
    logic [2:0]       n_typed;
    element_t [0:3]   el;
  } stim_row_t;

  localparam element_t NIL    = '{1'b0, 2'd0, 1'b0, 1'b0};
  localparam element_t OFF1   = '{1'b0, 2'd1, 1'b0, 1'b0};
  localparam element_t OFF1_L = '{1'b0, 2'd1, 1'b0, 1'b1};
  localparam element_t BAD_E  = '{1'b0, 2'd1, 1'b1, 1'b1};
  localparam element_t DOT_E  = '{1'b1, 2'd1, 1'b0, 1'b0};
  localparam element_t DASH_E = '{1'b1, 2'd3, 1'b0, 1'b0};

  // n_typed of zero: expectation comes from the predictor
  stim_row_t dir_tab [N_DIR] = '{
    '{8'h00, 3'd1, {BAD_E, NIL, NIL, NIL}},
    '{8'hFF, 3'd1, {BAD_E, NIL, NIL, NIL}},
    '{8'h41, 3'd1, {BAD_E, NIL, NIL, NIL}},
    '{8'h5A, 3'd1, {BAD_E, NIL, NIL, NIL}},
    '{8'h60, 3'd1, {BAD_E, NIL, NIL, NIL}},
    '{8'h7B, 3'd1, {BAD_E, NIL, NIL, NIL}},
    '{8'h1F, 3'd1, {BAD_E, NIL, NIL, NIL}},
    '{8'h21, 3'd1, {BAD_E, NIL, NIL, NIL}},
    '{8'h80, 3'd1, {BAD_E, NIL, NIL, NIL}},
    '{8'h7F, 3'd1, {BAD_E, NIL, NIL, NIL}},
    '{8'h20, 3'd4, {OFF1, OFF1, OFF1, OFF1_L}},
    '{8'h65, 3'd4, {DOT_E, OFF1, OFF1, OFF1_L}},
    '{8'h20, 3'd4, {OFF1, OFF1, OFF1, OFF1_L}},
    '{8'h74, 3'd4, {DASH_E, OFF1, OFF1, OFF1_L}},
    '{8'h61, 3'd0, {NIL, NIL, NIL, NIL}},
    '{8'h7A, 3'd0, {NIL, NIL, NIL, NIL}},
    '{8'h71, 3'd0, {NIL, NIL, NIL, NIL}},
    '{8'h68, 3'd0, {NIL, NIL, NIL, NIL}},
    '{8'h6F, 3'd0, {NIL, NIL, NIL, NIL}},
    '{8'h62, 3'd0, {NIL, NIL, NIL, NIL}},
    '{8'h6A, 3'd0, {NIL, NIL, NIL, NIL}},
    '{8'h79, 3'd0, {NIL, NIL, NIL, NIL}},
    '{8'h70, 3'd0, {NIL, NIL, NIL, NIL}},
    '{8'h6D, 3'd0, {NIL, NIL, NIL, NIL}}
  };

  string morse_tab [26] = '{
    ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
    "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
    "..-", "...-", ".--", "-..-", "-.--", "--.."
  };

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       start     = 1'b0;
  logic [7:0] char_code = 8'h00;
  logic       busy;
  logic       strobe;
  logic       key_on;
  logic [1:0] length_units;
  logic       bad_char;
  logic       last;

  element_t pending_elems [$];
  element_t want;
  int       n_errors  = 0;
  int       n_checked = 0;
  int       n_letters = 0;
  int       n_spaces  = 0;
  int       n_bad     = 0;
  int       n_cycles  = 0;

  morse_character_keyer_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .char_code    (char_code),
    .strobe       (strobe),
    .key_on       (key_on),
    .length_units (length_units),
    .bad_char     (bad_char),
    .last         (last)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    n_errors++;
    if (n_errors <= 40)
      $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // keying elements for one character word, in send order
  function automatic void predict_elements(input logic [7:0] c);
    element_t elems [10];
    string    pat;
    int       n;
    n = 0;
    if (c >= LETTER_A && c <= LETTER_Z) begin
      pat = morse_tab[int'(c - LETTER_A)];
      for (int k = 0; k < pat.len(); k++) begin
        elems[n++] = '{1'b1, (pat[k] == "-") ? DASH_LEN : 2'd1, 1'b0, 1'b0};
        elems[n++] = OFF1;
      end
      elems[n++] = OFF1;
      elems[n++] = OFF1;
    end else if (c == SPACE_CHAR) begin
      for (int k = 0; k < 4; k++)
        elems[n++] = OFF1;
    end else begin
      elems[n++] = '{1'b0, 2'd1, 1'b1, 1'b0};
    end
    elems[n-1].last = 1'b1;
    for (int k = 0; k < n; k++)
      pending_elems.push_back(elems[k]);
  endfunction

  // returns at the accepting edge
  task automatic accept_word(input logic [7:0] c);
    start     <= 1'b1;
    char_code <= c;
    do @(posedge clk); while (busy);
    if (c >= LETTER_A && c <= LETTER_Z) n_letters++;
    else if (c == SPACE_CHAR)          n_spaces++;
    else                               n_bad++;
  endtask

  task automatic hold_off(input int n);
    if (n > 0) begin
      start     <= 1'b0;
      char_code <= 8'($urandom);
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(99, 0);
    if (r < 60)      return LETTER_A + 8'($urandom_range(25, 0));
    else if (r < 75) return SPACE_CHAR;
    else             return 8'($urandom_range(255, 0));
  endfunction

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d elements outstanding",
               n_cycles, pending_elems.size());
      $display("morse_character_keyer_unit_tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (pending_elems.size() == 0) begin
        report_mismatch($sformatf("unexpected element on=%0b len=%0d bad=%0b last=%0b",
                                  key_on, length_units, bad_char, last));
      end else begin
        want = pending_elems.pop_front();
        n_checked++;
        if (key_on !== want.key_on)
          report_mismatch($sformatf("key_on %0b, want %0b", key_on, want.key_on));
        if (length_units !== want.length_units)
          report_mismatch($sformatf("length_units %0d, want %0d",
                                    length_units, want.length_units));
        if (bad_char !== want.bad_char)
          report_mismatch($sformatf("bad_char %0b, want %0b", bad_char, want.bad_char));
        if (last !== want.last)
          report_mismatch($sformatf("last %0b, want %0b", last, want.last));
      end
    end
  end

  initial begin
    logic [7:0] c;
    int         gap;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIR; i++) begin
      accept_word(dir_tab[i].code);
      if (dir_tab[i].n_typed == 0)
        predict_elements(dir_tab[i].code);
      else
        for (int k = 0; k < dir_tab[i].n_typed; k++)
          pending_elems.push_back(dir_tab[i].el[k]);
      hold_off($urandom_range(10, 0));
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      c = pick_char();
      accept_word(c);
      predict_elements(c);
      if (i == N_RANDOM - 1) begin
        start <= 1'b0;
      end else if (i == PRESSURE_AT) begin
        start <= 1'b0;
        do @(posedge clk); while (pending_elems.size() != 0);
      end else begin
        gap = (i >= 100 && i < 160) ? 0 : $urandom_range(10, 0);
        hold_off(gap);
      end
    end

    while (pending_elems.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d letters, %0d spaces, %0d uncoded characters",
             n_letters, n_spaces, n_bad);
    $display("checked %0d keying elements, %0d mismatches", n_checked, n_errors);
    if (n_errors == 0)
      $display("morse_character_keyer_unit_tb: PASS");
    else
      $display("morse_character_keyer_unit_tb: FAIL");
    $finish;
  end

endmodule
